// ----- rtl/core/usrr_pkg.sv -----
// ----------------------------------------------------------------------------
// usrr_pkg
// shared types, codes, descriptor tables and helpers of the standard
// request responder
// ----------------------------------------------------------------------------
package usrr_pkg;

  // request codes (bRequest)
  localparam logic [7:0] ReqGetStatus        = 8'h00;
  localparam logic [7:0] ReqSetAddress       = 8'h05;
  localparam logic [7:0] ReqGetDescriptor    = 8'h06;
  localparam logic [7:0] ReqSetConfiguration = 8'h09;

  // descriptor types (wValue high byte)
  localparam logic [7:0] DescTypeDevice = 8'h01;
  localparam logic [7:0] DescTypeConfig = 8'h02;

  localparam int unsigned DevDescLen = 18;
  localparam int unsigned CfgDescLen = 25;
  localparam int unsigned BulkLen    = 12;

  localparam int unsigned IdxW = 5;  // byte index within a run, up to 25

  localparam logic [15:0] VendorIdReset  = 16'h1209;
  localparam logic [15:0] ProductIdReset = 16'h0002;

  // configuration register indices
  localparam logic [1:0] CfgIdxVendorId  = 2'd0;
  localparam logic [1:0] CfgIdxProductId = 2'd1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_STALL = 2'd2,
    KIND_BULK  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    RUN_DEV    = 2'd0,
    RUN_CFG    = 2'd1,
    RUN_STATUS = 2'd2,
    RUN_BULK   = 2'd3
  } run_e;

  // device state word kept in the state memory
  typedef struct packed {
    logic [6:0]  address;
    logic        configured;
    logic [15:0] count_bcd;
  } dev_state_t;

  // request to the state memory
  typedef struct packed {
    logic       rd_en;
    logic       wr_en;
    dev_state_t wdata;
  } ram_req_t;

  // one result word
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       last;
    logic [6:0] device_address;
    logic       configured;
  } result_t;

  localparam logic [7:0] DevDescRom [DevDescLen] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h40,
    8'h09, 8'h12, 8'h02, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01
  };

  localparam logic [7:0] CfgDescRom [CfgDescLen] = '{
    8'h09, 8'h02, 8'h19, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00
  };

  localparam logic [7:0] BulkTemplate [BulkLen] = '{
    8'h42, 8'h55, 8'h4C, 8'h4B, 8'h31, 8'h20,
    8'h30, 8'h30, 8'h30, 8'h30, 8'h0D, 8'h0A
  };

  // four-digit bcd increment, digits above nine treated as nine
  function automatic logic [15:0] bcd_increment(input logic [15:0] v);
    logic [15:0] res;
    logic        carry;
    logic [4:0]  digit;
    res   = '0;
    carry = 1'b1;
    for (int d = 0; d < 4; d++) begin
      digit = {1'b0, v[4*d +: 4]};
      if (digit > 5'd9) digit = 5'd9;
      digit = digit + {4'd0, carry};
      if (digit >= 5'd10) begin
        digit = 5'd0;
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      res[4*d +: 4] = digit[3:0];
    end
    return res;
  endfunction

  // data byte at a given place of a run
  function automatic logic [7:0] run_byte(input run_e run, input logic [IdxW-1:0] idx,
                                          input logic [15:0] vid, input logic [15:0] pid,
                                          input logic [15:0] bcd);
    logic [7:0] b;
    b = 8'h00;
    case (run)
      RUN_DEV: begin
        case (idx)
          5'd8:    b = vid[7:0];
          5'd9:    b = vid[15:8];
          5'd10:   b = pid[7:0];
          5'd11:   b = pid[15:8];
          default: b = (idx < 5'(DevDescLen)) ? DevDescRom[idx] : 8'h00;
        endcase
      end
      RUN_CFG:    b = (idx < 5'(CfgDescLen)) ? CfgDescRom[idx] : 8'h00;
      RUN_STATUS: b = 8'h00;
      RUN_BULK: begin
        case (idx)
          5'd6:    b = 8'h30 + {4'h0, bcd[15:12]};
          5'd7:    b = 8'h30 + {4'h0, bcd[11:8]};
          5'd8:    b = 8'h30 + {4'h0, bcd[7:4]};
          5'd9:    b = 8'h30 + {4'h0, bcd[3:0]};
          default: b = (idx < 5'(BulkLen)) ? BulkTemplate[idx[3:0]] : 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/usrr_state_ram.sv -----
// ----------------------------------------------------------------------------
// usrr_state_ram
// single-word synchronous state memory, registered read, valid bit for reset
// ----------------------------------------------------------------------------
module usrr_state_ram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  usrr_pkg::ram_req_t    req_i,
  output usrr_pkg::dev_state_t  rdata_o
);

  usrr_pkg::dev_state_t mem_q [1];
  usrr_pkg::dev_state_t rdata_q;
  logic                 valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[0] <= req_i.wdata;
    end
  end

  // unwritten entry reads as the reset state
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= valid_q ? mem_q[0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.wr_en) begin
      valid_q <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/usrr_seq.sv -----
// ----------------------------------------------------------------------------
// usrr_seq
// request decoder and run sequencer: read state, update, write back, emit
// ----------------------------------------------------------------------------
module usrr_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [7:0]            request_code_i,
  input  logic [15:0]           request_value_i,
  input  logic [15:0]           request_length_i,
  input  logic [15:0]           vendor_id_i,
  input  logic [15:0]           product_id_i,
  output usrr_pkg::ram_req_t    ram_req_o,
  input  usrr_pkg::dev_state_t  ram_rdata_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output usrr_pkg::result_t     res_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_RUN  = 3'b100
  } seq_state_e;

  seq_state_e state_q, state_d;

  logic        func_q;
  logic [7:0]  code_q;
  logic [15:0] value_q;
  logic [15:0] length_q;

  usrr_pkg::dev_state_t cur_q, cur_d;
  usrr_pkg::run_e       run_q, run_d;
  usrr_pkg::kind_e      tail_kind_q, tail_kind_d;
  logic                 has_tail_q, has_tail_d;
  logic [usrr_pkg::IdxW-1:0] cnt_q, cnt_d;
  logic [usrr_pkg::IdxW-1:0] idx_q, idx_d;

  logic in_fire, res_fire, in_data;
  logic [usrr_pkg::IdxW-1:0] dev_cnt, cfg_cnt;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign res_valid_o = (state_q == S_RUN);
  assign res_fire   = res_valid_o && res_ready_i;
  assign in_data    = (idx_q < cnt_q);

  assign dev_cnt = (length_q < 16'(usrr_pkg::DevDescLen)) ? length_q[usrr_pkg::IdxW-1:0]
                                                           : usrr_pkg::IdxW'(usrr_pkg::DevDescLen);
  assign cfg_cnt = (length_q < 16'(usrr_pkg::CfgDescLen)) ? length_q[usrr_pkg::IdxW-1:0]
                                                           : usrr_pkg::IdxW'(usrr_pkg::CfgDescLen);

  // result word
  always_comb begin
    res_o.device_address = cur_q.address;
    res_o.configured     = cur_q.configured;
    if (in_data) begin
      res_o.kind      = (run_q == usrr_pkg::RUN_BULK) ? usrr_pkg::KIND_BULK
                                                      : usrr_pkg::KIND_DATA;
      res_o.data_byte = usrr_pkg::run_byte(run_q, idx_q, vendor_id_i, product_id_i,
                                           cur_q.count_bcd);
      res_o.last      = !has_tail_q && (idx_q == cnt_q - 1'b1);
    end else begin
      res_o.kind      = tail_kind_q;
      res_o.data_byte = 8'h00;
      res_o.last      = 1'b1;
    end
  end

  // state memory access
  always_comb begin
    ram_req_o.rd_en = in_fire;
    ram_req_o.wr_en = (state_q == S_READ);
    ram_req_o.wdata = cur_d;
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    run_d       = run_q;
    tail_kind_d = tail_kind_q;
    has_tail_d  = has_tail_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_READ;
      end
      S_READ: begin
        cur_d       = ram_rdata_i;
        run_d       = usrr_pkg::RUN_STATUS;
        tail_kind_d = usrr_pkg::KIND_ACK;
        has_tail_d  = 1'b1;
        cnt_d       = '0;
        idx_d       = '0;
        state_d     = S_RUN;
        if (func_q) begin
          if (ram_rdata_i.configured) begin
            cur_d.count_bcd = usrr_pkg::bcd_increment(ram_rdata_i.count_bcd);
            run_d           = usrr_pkg::RUN_BULK;
            has_tail_d      = 1'b0;
            cnt_d           = usrr_pkg::IdxW'(usrr_pkg::BulkLen);
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          case (code_q)
            usrr_pkg::ReqGetDescriptor: begin
              if (value_q[15:8] == usrr_pkg::DescTypeDevice) begin
                run_d = usrr_pkg::RUN_DEV;
                cnt_d = dev_cnt;
              end else if (value_q[15:8] == usrr_pkg::DescTypeConfig) begin
                run_d = usrr_pkg::RUN_CFG;
                cnt_d = cfg_cnt;
              end else begin
                tail_kind_d = usrr_pkg::KIND_STALL;
              end
            end
            usrr_pkg::ReqSetAddress: cur_d.address = value_q[6:0];
            usrr_pkg::ReqSetConfiguration: begin
              if (value_q[7:0] == 8'd1) cur_d.configured = 1'b1;
            end
            usrr_pkg::ReqGetStatus: cnt_d = usrr_pkg::IdxW'(2);
            default: tail_kind_d = usrr_pkg::KIND_STALL;
          endcase
        end
      end
      S_RUN: begin
        if (res_fire) begin
          idx_d = idx_q + 1'b1;
          if (res_o.last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= func_i;
      code_q   <= request_code_i;
      value_q  <= request_value_i;
      length_q <= request_length_i;
    end
    cur_q       <= cur_d;
    run_q       <= run_d;
    tail_kind_q <= tail_kind_d;
    has_tail_q  <= has_tail_d;
    cnt_q       <= cnt_d;
    idx_q       <= idx_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("sequencer state not one-hot");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> state_q == S_READ)
    else $error("accepted request did not start a state read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_fire && res_o.last |=> state_q == S_IDLE)
    else $error("run did not end after its last word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_valid_o |-> idx_q <= cnt_q)
    else $error("run index overran its byte count");

endmodule

// ----- rtl/core/usb_standard_request_responder_core.sv -----
// ----------------------------------------------------------------------------
// usb_standard_request_responder_core
// fixed-function usb device standard request responder
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i/in_ready_o) takes one word: a setup request
//   (func_i low) or a bulk IN buffer-empty event (func_i high). each word
//   produces a run of result words on the output channel (out_valid_o and
//   out_ready_i), one per cycle unless stalled, the final one flagged by last_o
//   a bulk event on an unconfigured device produces no words at all
//   order: accept, the registered state memory read, the update and write-back
//   in the read state, then the first result word enters the output register
//   from the run state. a run holds 1 to 26 words, one word per cycle when not
//   stalled, behind the single read port of the state memory; a new item is
//   accepted only once the previous run has been handed to the output register
//   output stall: the output register holds its word and the sequencer waits,
//   nothing is dropped
//   configuration port: vendor_id (index 0) and product_id (index 1), always
//   ready, other indices ignored; write only while idle
//   reset: address 0, not configured, bulk count 0000, ids to defaults;
//   the state memory reads as cleared until its first write
// ----------------------------------------------------------------------------
module usb_standard_request_responder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_length_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [6:0]  device_address_o,
  output logic        configured_o
);

  logic [15:0] vendor_id_q, product_id_q;

  usrr_pkg::ram_req_t   ram_req;
  usrr_pkg::dev_state_t ram_rdata;

  logic              res_valid, res_ready;
  usrr_pkg::result_t res, out_q;
  logic              out_valid_q;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vendor_id_q  <= usrr_pkg::VendorIdReset;
      product_id_q <= usrr_pkg::ProductIdReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        usrr_pkg::CfgIdxVendorId:  vendor_id_q  <= cfg_data_i;
        usrr_pkg::CfgIdxProductId: product_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // state memory: address, configured flag, bulk count
  usrr_state_ram u_state_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // decode, update and run sequencing
  usrr_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .request_code_i   (request_code_i),
    .request_value_i  (request_value_i),
    .request_length_i (request_length_i),
    .vendor_id_i      (vendor_id_q),
    .product_id_i     (product_id_q),
    .ram_req_o        (ram_req),
    .ram_rdata_i      (ram_rdata),
    .res_valid_o      (res_valid),
    .res_ready_i      (res_ready),
    .res_o            (res)
  );

  // output register, refilled in the cycle its word leaves
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign data_byte_o      = out_q.data_byte;
  assign last_o           = out_q.last;
  assign device_address_o = out_q.device_address;
  assign configured_o     = out_q.configured;

endmodule

// ----- sim/usb_standard_request_responder_core_test.sv -----
// ----------------------------------------------------------------------------
// usb_standard_request_responder_core_test
// self-checking bench for the standard request responder: setup requests and
// bulk buffer-empty events go in through a paced driver, a scoreboard predicts
// every result word and checks the output channel field by field
// ----------------------------------------------------------------------------
module usb_standard_request_responder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // watchdog ceiling on the total simulated cycles of the whole bench
  localparam int unsigned CycleLimit = 2_000_000;
  // idle time waited after the last expected word before the bench moves on
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxGap = 12;
  localparam int unsigned BurstEvents = 60;

  // register indices outside the map, writes there must be ignored
  localparam logic [1:0] RegIdxSpare2 = 2'd2;
  localparam logic [1:0] RegIdxSpare3 = 2'd3;

  // codes and descriptor types that the block must refuse
  localparam logic [7:0] ReqClearFeature = 8'h01;
  localparam logic [7:0] ReqUnknownTop   = 8'hFF;
  localparam logic [7:0] DescTypeNone    = 8'h00;
  localparam logic [7:0] DescTypeString  = 8'h03;
  localparam logic [7:0] DescTypeTop     = 8'hFF;

  localparam logic FuncSetup = 1'b0;
  localparam logic FuncBulk  = 1'b1;

  localparam int unsigned DeviceDescBytes = 18;
  localparam int unsigned ConfigDescBytes = 25;
  localparam int unsigned BulkLineBytes   = 12;

  // bench copies of the descriptor tables, ids patched in on the fly
  localparam logic [7:0] DeviceDesc [DeviceDescBytes] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h40,
    8'h09, 8'h12, 8'h02, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01
  };
  localparam logic [7:0] ConfigDesc [ConfigDescBytes] = '{
    8'h09, 8'h02, 8'h19, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h32,
    8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    8'h07, 8'h05, 8'h81, 8'h02, 8'h40, 8'h00, 8'h00
  };
  // "BULK1 " ahead of the four count digits
  localparam logic [7:0] BulkHead [6] = '{8'h42, 8'h55, 8'h4C, 8'h4B, 8'h31, 8'h20};

  typedef struct {
    logic        func;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] length;
    int unsigned gap;
  } request_t;

  typedef struct {
    usrr_pkg::kind_e kind;
    logic [7:0]      data;
    logic            last;
    logic [6:0]      addr;
    logic            conf;
  } reply_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index = usrr_pkg::CfgIdxVendorId;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic        func = FuncSetup;
  logic [7:0]  request_code = '0;
  logic [15:0] request_value = '0;
  logic [15:0] request_length = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic        last_o;
  logic [6:0]  device_address_o;
  logic        configured_o;

  usb_standard_request_responder_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .func_i           (func),
    .request_code_i   (request_code),
    .request_value_i  (request_value),
    .request_length_i (request_length),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .last_o           (last_o),
    .device_address_o (device_address_o),
    .configured_o     (configured_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  request_t    pending_q [$];   // requests waiting to be driven
  reply_word_t reply_q [$];     // predicted words not yet seen
  request_t    on_wire;         // request currently offered to the block

  int unsigned in_issued, in_taken;
  int unsigned gap_left;
  bit          gap_loaded;
  int unsigned stall_left;
  int unsigned words_seen, words_seen_prev;
  int unsigned mismatches, cfg_writes, bulk_packets, cycles;
  bit          idle_on = 1'b1;  // random gaps and stalls enabled

  // mirror of the device: ids, address, configured flag, bcd packet count
  logic [15:0] mirror_vid = usrr_pkg::VendorIdReset;
  logic [15:0] mirror_pid = usrr_pkg::ProductIdReset;
  logic [6:0]  mirror_addr = '0;
  logic        mirror_conf = 1'b0;
  logic [15:0] mirror_count = '0;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // decimal increment of the four-digit count, digits over nine read as nine,
  // 9999 rolls over to 0000
  function automatic logic [15:0] bump_count(input logic [15:0] c);
    int unsigned dec;
    int unsigned d;
    int unsigned digit;
    logic [15:0] nxt;
    dec = 0;
    for (d = 4; d > 0; d--) begin
      digit = c[4*(d-1) +: 4];
      if (digit > 9) digit = 9;
      dec = dec * 10 + digit;
    end
    dec = (dec + 1) % 10000;
    for (d = 0; d < 4; d++) begin
      nxt[4*d +: 4] = 4'(dec % 10);
      dec = dec / 10;
    end
    return nxt;
  endfunction

  function automatic logic [7:0] device_desc_byte(input int unsigned i);
    case (i)
      8:       return mirror_vid[7:0];
      9:       return mirror_vid[15:8];
      10:      return mirror_pid[7:0];
      11:      return mirror_pid[15:8];
      default: return DeviceDesc[5'(i)];
    endcase
  endfunction

  function automatic logic [7:0] bulk_line_byte(input int unsigned i);
    if (i < 6) return BulkHead[3'(i)];
    if (i < 10) return 8'h30 + {4'h0, mirror_count[4*(9-i) +: 4]};
    if (i == 10) return 8'h0D;
    return 8'h0A;
  endfunction

  // every word carries the address and flag as they stand after the update
  task automatic push_reply(input usrr_pkg::kind_e k, input logic [7:0] d, input logic l);
    reply_word_t w;
    w.kind = k;
    w.data = d;
    w.last = l;
    w.addr = mirror_addr;
    w.conf = mirror_conf;
    reply_q.push_back(w);
  endtask

  task automatic predict_reply(input request_t r);
    logic [7:0]  dtype;
    int unsigned n;
    int unsigned i;
    dtype = r.value[15:8];
    if (r.func == FuncBulk) begin
      // an unconfigured device ignores the event entirely
      if (!mirror_conf) return;
      mirror_count = bump_count(mirror_count);
      bulk_packets++;
      for (i = 0; i < BulkLineBytes; i++)
        push_reply(usrr_pkg::KIND_BULK, bulk_line_byte(i), i == BulkLineBytes - 1);
      return;
    end
    case (r.code)
      usrr_pkg::ReqGetDescriptor: begin
        if (dtype == usrr_pkg::DescTypeDevice) begin
          n = (32'(r.length) < DeviceDescBytes) ? 32'(r.length) : DeviceDescBytes;
          for (i = 0; i < n; i++)
            push_reply(usrr_pkg::KIND_DATA, device_desc_byte(i), 1'b0);
          push_reply(usrr_pkg::KIND_ACK, 8'h00, 1'b1);
        end else if (dtype == usrr_pkg::DescTypeConfig) begin
          n = (32'(r.length) < ConfigDescBytes) ? 32'(r.length) : ConfigDescBytes;
          for (i = 0; i < n; i++)
            push_reply(usrr_pkg::KIND_DATA, ConfigDesc[5'(i)], 1'b0);
          push_reply(usrr_pkg::KIND_ACK, 8'h00, 1'b1);
        end else begin
          push_reply(usrr_pkg::KIND_STALL, 8'h00, 1'b1);
        end
      end
      usrr_pkg::ReqSetAddress: begin
        mirror_addr = r.value[6:0];
        push_reply(usrr_pkg::KIND_ACK, 8'h00, 1'b1);
      end
      usrr_pkg::ReqSetConfiguration: begin
        // any other value is acknowledged but never clears the flag
        if (r.value[7:0] == 8'd1) mirror_conf = 1'b1;
        push_reply(usrr_pkg::KIND_ACK, 8'h00, 1'b1);
      end
      usrr_pkg::ReqGetStatus: begin
        // wLength plays no part here
        push_reply(usrr_pkg::KIND_DATA, 8'h00, 1'b0);
        push_reply(usrr_pkg::KIND_DATA, 8'h00, 1'b0);
        push_reply(usrr_pkg::KIND_ACK, 8'h00, 1'b1);
      end
      default: push_reply(usrr_pkg::KIND_STALL, 8'h00, 1'b1);
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // request driver: one word offered at a time, gap drawn per word
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : request_driver
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid;
      // the word on the wire was taken at the last rising edge
      if (in_valid && in_taken == in_issued) nxt_valid = 1'b0;
      if (!nxt_valid && pending_q.size() > 0) begin
        if (!gap_loaded) begin
          gap_left   = pending_q[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          on_wire        = pending_q.pop_front();
          func           <= on_wire.func;
          request_code   <= on_wire.code;
          request_value  <= on_wire.value;
          request_length <= on_wire.length;
          nxt_valid      = 1'b1;
          gap_loaded     = 1'b0;
          in_issued++;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // result side back-pressure: fresh stall drawn after every word
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : reply_ready_driver
    if (rst_ni) begin
      if (words_seen != words_seen_prev) begin
        words_seen_prev = words_seen;
        stall_left      = idle_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and scoreboard, both channels sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : reply_monitor
    reply_word_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        predict_reply(on_wire);
        in_taken++;
      end
      if (out_valid_o && out_ready) begin
        words_seen++;
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected (kind %0d data %02h)",
                                    words_seen, kind_o, data_byte_o));
        end else begin
          want = reply_q.pop_front();
          if (kind_o !== want.kind)
            report_mismatch($sformatf("word %0d kind %0d, want %s",
                                      words_seen, kind_o, want.kind.name()));
          if (data_byte_o !== want.data)
            report_mismatch($sformatf("word %0d data %02h, want %02h",
                                      words_seen, data_byte_o, want.data));
          if (last_o !== want.last)
            report_mismatch($sformatf("word %0d last %b, want %b",
                                      words_seen, last_o, want.last));
          if (device_address_o !== want.addr)
            report_mismatch($sformatf("word %0d address %0d, want %0d",
                                      words_seen, device_address_o, want.addr));
          if (configured_o !== want.conf)
            report_mismatch($sformatf("word %0d configured %b, want %b",
                                      words_seen, configured_o, want.conf));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, reply_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_request(input logic f, input logic [7:0] code,
                               input logic [15:0] value, input logic [15:0] length);
    request_t r;
    r.func   = f;
    r.code   = code;
    r.value  = value;
    r.length = length;
    r.gap    = idle_on ? $urandom_range(0, MaxGap) : 0;
    pending_q.push_back(r);
  endtask

  // sender held back until the block has nothing left in flight
  task automatic wait_until_idle();
    while (pending_q.size() != 0 || in_valid || in_taken != in_issued ||
           reply_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // only ever called with the block idle
  task automatic write_register(input logic [1:0] idx, input logic [15:0] d);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == usrr_pkg::CfgIdxVendorId) mirror_vid = d;
    else if (idx == usrr_pkg::CfgIdxProductId) mirror_pid = d;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // short lengths mostly, so truncation points get hit often
  function automatic logic [15:0] pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 16'($urandom_range(0, 30));
    if (sel < 80) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic queue_random_request();
    int unsigned sel;
    int unsigned tsel;
    logic [7:0]  dtype;
    logic [15:0] value;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      tsel = $urandom_range(0, 99);
      if (tsel < 45) dtype = usrr_pkg::DescTypeDevice;
      else if (tsel < 90) dtype = usrr_pkg::DescTypeConfig;
      else dtype = 8'($urandom);
      queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor, {dtype, 8'($urandom)},
                    pick_length());
    end else if (sel < 48) begin
      queue_request(FuncBulk, 8'($urandom), 16'($urandom), 16'($urandom));
    end else if (sel < 58) begin
      queue_request(FuncSetup, usrr_pkg::ReqSetAddress, 16'($urandom), 16'($urandom));
    end else if (sel < 66) begin
      value = 16'($urandom);
      if ($urandom_range(0, 1) == 0) value[7:0] = 8'd1;
      queue_request(FuncSetup, usrr_pkg::ReqSetConfiguration, value, 16'($urandom));
    end else if (sel < 76) begin
      queue_request(FuncSetup, usrr_pkg::ReqGetStatus, 16'($urandom), 16'($urandom));
    end else begin
      queue_request(FuncSetup, 8'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      // every forty words pick whether this stretch idles
      if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == n / 2) wait_until_idle();
      while (pending_q.size() > 4) @(negedge clk_i);
      queue_random_request();
    end
    wait_until_idle();
    idle_on = 1'b1;
  endtask

  initial begin : stimulus
    int unsigned i;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset ids, not yet configured
    queue_request(FuncBulk, 8'hFF, 16'hFFFF, 16'hFFFF);   // ignored while unconfigured
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor,
                  {usrr_pkg::DescTypeDevice, 8'h00}, 16'hFFFF);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor,
                  {usrr_pkg::DescTypeConfig, 8'hFF}, 16'hFFFF);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor,
                  {usrr_pkg::DescTypeDevice, 8'h00}, 16'h0000);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor,
                  {usrr_pkg::DescTypeConfig, 8'h00}, 16'h0000);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor,
                  {usrr_pkg::DescTypeDevice, 8'h00}, 16'd17);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor,
                  {usrr_pkg::DescTypeDevice, 8'h00}, 16'd18);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor,
                  {usrr_pkg::DescTypeConfig, 8'h00}, 16'd24);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor,
                  {usrr_pkg::DescTypeConfig, 8'h00}, 16'd26);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor,
                  {usrr_pkg::DescTypeConfig, 8'h00}, 16'd1);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor, {DescTypeNone, 8'h00}, 16'h0040);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor, {DescTypeString, 8'h00}, 16'h00FF);
    queue_request(FuncSetup, usrr_pkg::ReqGetDescriptor, {DescTypeTop, 8'hFF}, 16'hFFFF);
    queue_request(FuncSetup, usrr_pkg::ReqSetAddress, 16'hFFFF, 16'hFFFF);
    queue_request(FuncSetup, usrr_pkg::ReqGetStatus, 16'h0000, 16'h0000);
    queue_request(FuncSetup, usrr_pkg::ReqGetStatus, 16'hFFFF, 16'hFFFF);
    queue_request(FuncSetup, usrr_pkg::ReqSetAddress, 16'h0080, 16'h0000);   // upper bits dropped
    queue_request(FuncSetup, ReqUnknownTop, 16'hFFFF, 16'hFFFF);
    queue_request(FuncSetup, ReqClearFeature, 16'h0000, 16'h0000);
    queue_request(FuncSetup, usrr_pkg::ReqSetConfiguration, 16'h0100, 16'h0000);   // flag unchanged
    queue_request(FuncBulk, 8'h00, 16'h0000, 16'h0000);
    queue_request(FuncSetup, usrr_pkg::ReqSetConfiguration, 16'hFF01, 16'hFFFF);
    queue_request(FuncSetup, usrr_pkg::ReqSetConfiguration, 16'h0000, 16'h0000);   // never clears
    queue_request(FuncBulk, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_request(FuncBulk, 8'h00, 16'h0000, 16'h0000);
    wait_until_idle();

    run_random(110);

    // ids at the low and high ends, stray indices must not land anywhere
    write_register(usrr_pkg::CfgIdxVendorId, 16'h0000);
    write_register(usrr_pkg::CfgIdxProductId, 16'hFFFF);
    write_register(RegIdxSpare2, 16'hFFFF);
    write_register(RegIdxSpare3, 16'h5A5A);
    run_random(110);

    // back-to-back burst of bulk events, no gaps and no stalls
    idle_on = 1'b0;
    for (i = 0; i < BurstEvents; i++) begin
      while (pending_q.size() > 4) @(negedge clk_i);
      queue_request(FuncBulk, 8'($urandom), 16'($urandom), 16'($urandom));
    end
    wait_until_idle();
    idle_on = 1'b1;

    write_register(usrr_pkg::CfgIdxVendorId, 16'hFFFF);
    write_register(usrr_pkg::CfgIdxProductId, 16'h0000);
    run_random(90);

    write_register(usrr_pkg::CfgIdxVendorId, 16'($urandom));
    write_register(usrr_pkg::CfgIdxProductId, 16'($urandom));
    run_random(80);

    foreach (reply_q[k])
      report_mismatch($sformatf("expected word left over: %s data %02h",
                                reply_q[k].kind.name(), reply_q[k].data));

    $display("summary: %0d requests and events taken, %0d words checked, %0d register writes",
             in_taken, words_seen, cfg_writes);
    $display("summary: %0d bulk lines, final count %04h, %0d mismatches",
             bulk_packets, mirror_count, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
